[rtl/patan2_pkg.sv]
// Shared constants and types for the polynomial atan2 pipeline.
package patan2_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_WIDTH_DEF = 16;

  // Ratio r is signed Q1.16; its magnitude needs 17 quotient bits.
  localparam int R_FRAC  = 16;
  localparam int R_QBITS = R_FRAC + 1;
  localparam int R_W     = R_QBITS + 1;

  // Polynomial coefficients and angle offsets in Q16 radians.
  localparam int COEF_C1          = -65250;
  localparam int COEF_C3          = 18954;
  localparam int COEF_C5          = 5176;
  localparam int QUARTER_PI       = 51472;
  localparam int THREE_QUARTER_PI = 154416;
  localparam int TWO_PI           = 411775;
  localparam int TWO_PI_X2        = 2 * TWO_PI;

  // Width of the wrapped angle and of the divisor in the output scaler.
  localparam int SCALE_DW = 20;
  localparam int THETA_W  = 20;

  // The wrapped angle stays below 2^SCALE_SHIFT, which keeps the reciprocal
  // estimate in the scaler within two of the true quotient.
  localparam int SCALE_SHIFT = 19;

  localparam int FRONT_LAT = 3;
  localparam int POLY_LAT  = 10;
  localparam int SCALE_LAT = 3;

  typedef struct packed {
    logic neg;
    logic xneg;
    logic yneg;
    logic zero;
  } flags_t;

endpackage

[rtl/patan2_front.sv]
// Front end: forms numerator, denominator and the rounded dividend of the ratio.
module patan2_front #(
  parameter int COORD_WIDTH = patan2_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [COORD_WIDTH-1:0]     y_in,
  input  logic signed [COORD_WIDTH-1:0]     x_in,
  output logic                              out_valid,
  output logic [COORD_WIDTH:0]              rem0,
  output logic [patan2_pkg::R_QBITS-1:0]    low,
  output logic [COORD_WIDTH:0]              den,
  output patan2_pkg::flags_t                flags
);

  localparam int DVD_W = COORD_WIDTH + patan2_pkg::R_QBITS;

  logic                          v1;
  logic signed [COORD_WIDTH-1:0] x1;
  logic signed [COORD_WIDTH-1:0] y1;

  logic                          v2;
  logic signed [COORD_WIDTH:0]   num2;
  logic [COORD_WIDTH:0]          den2;
  patan2_pkg::flags_t            flags2;

  logic signed [COORD_WIDTH:0]   num2_next;
  logic [COORD_WIDTH:0]          den2_next;
  patan2_pkg::flags_t            flags2_next;
  logic [COORD_WIDTH:0]          mag;
  logic [DVD_W-1:0]              dvd;

  always_comb begin
    logic signed [COORD_WIDTH:0] x_ext;
    logic signed [COORD_WIDTH:0] y_ext;
    logic signed [COORD_WIDTH:0] yabs;
    x_ext = {x1[COORD_WIDTH-1], x1};
    y_ext = {y1[COORD_WIDTH-1], y1};
    yabs  = y1[COORD_WIDTH-1] ? -y_ext : y_ext;
    if (x1[COORD_WIDTH-1]) begin
      num2_next = x_ext + yabs;
      den2_next = yabs - x_ext;
    end else begin
      num2_next = x_ext - yabs;
      den2_next = x_ext + yabs;
    end
    flags2_next.neg  = num2_next[COORD_WIDTH];
    flags2_next.xneg = x1[COORD_WIDTH-1];
    flags2_next.yneg = y1[COORD_WIDTH-1];
    flags2_next.zero = (x1 == '0) && (y1 == '0);
  end

  // Rounded ratio: (|num| * 2^16 + den/2) / den. The top bits seed the remainder.
  always_comb begin
    mag = num2[COORD_WIDTH] ? -num2 : num2;
    dvd = {mag, {patan2_pkg::R_FRAC{1'b0}}} + DVD_W'(den2 >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    x1         <= x_in;
    y1         <= y_in;
    num2       <= num2_next;
    den2       <= den2_next;
    flags2     <= flags2_next;
    rem0       <= {1'b0, dvd[DVD_W-1:patan2_pkg::R_QBITS]};
    low        <= dvd[patan2_pkg::R_QBITS-1:0];
    den        <= den2;
    flags      <= flags2;
  end

endmodule

[rtl/patan2_divpipe.sv]
// Pipelined restoring divider: one quotient bit per register stage.
module patan2_divpipe #(
  parameter int DW    = 17,
  parameter int QBITS = 17,
  parameter int SBW   = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [DW-1:0]    in_rem,
  input  logic [QBITS-1:0] in_low,
  input  logic [DW-1:0]    in_div,
  input  logic [SBW-1:0]   in_side,
  output logic             out_valid,
  output logic [QBITS-1:0] out_quot,
  output logic [DW-1:0]    out_rem,
  output logic [SBW-1:0]   out_side
);

  logic [QBITS-1:0] vld;
  logic [DW-1:0]    rem  [QBITS];
  logic [QBITS-1:0] low  [QBITS];
  logic [DW-1:0]    dvs  [QBITS];
  logic [SBW-1:0]   side [QBITS];

  logic [QBITS-1:0] src_vld;
  logic [DW-1:0]    src_rem  [QBITS];
  logic [QBITS-1:0] src_low  [QBITS];
  logic [DW-1:0]    src_dvs  [QBITS];
  logic [SBW-1:0]   src_side [QBITS];

  logic [DW-1:0]    rem_next [QBITS];
  logic [QBITS-1:0] low_next [QBITS];

  always_comb begin
    src_vld[0]  = in_valid;
    src_rem[0]  = in_rem;
    src_low[0]  = in_low;
    src_dvs[0]  = in_div;
    src_side[0] = in_side;
    for (int i = 1; i < QBITS; i++) begin
      src_vld[i]  = vld[i-1];
      src_rem[i]  = rem[i-1];
      src_low[i]  = low[i-1];
      src_dvs[i]  = dvs[i-1];
      src_side[i] = side[i-1];
    end
  end

  // The dividend's low word shifts out at the top while quotient bits enter
  // at the bottom, so after the last stage it holds the quotient.
  always_comb begin
    logic [DW:0]   sh;
    logic [DW+1:0] df;
    for (int i = 0; i < QBITS; i++) begin
      sh = {src_rem[i], src_low[i][QBITS-1]};
      df = {1'b0, sh} - {2'b00, src_dvs[i]};
      if (!df[DW+1]) begin
        rem_next[i] = df[DW-1:0];
        low_next[i] = {src_low[i][QBITS-2:0], 1'b1};
      end else begin
        rem_next[i] = sh[DW-1:0];
        low_next[i] = {src_low[i][QBITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= src_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QBITS; i++) begin
      rem[i]  <= rem_next[i];
      low[i]  <= low_next[i];
      dvs[i]  <= src_dvs[i];
      side[i] <= src_side[i];
    end
  end

  assign out_valid = vld[QBITS-1];
  assign out_quot  = low[QBITS-1];
  assign out_rem   = rem[QBITS-1];
  assign out_side  = side[QBITS-1];

endmodule

[rtl/patan2_poly.sv]
// Polynomial arctangent of the ratio, sign handling and wrap into one turn.
module patan2_poly (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [patan2_pkg::R_QBITS-1:0]    in_quot,
  input  patan2_pkg::flags_t                in_flags,
  output logic                              out_valid,
  output logic [patan2_pkg::SCALE_DW-1:0]   turn_pos,
  output patan2_pkg::flags_t                out_flags
);

  localparam int RW = patan2_pkg::R_W;
  localparam int TW = patan2_pkg::THETA_W;
  localparam int NS = patan2_pkg::POLY_LAT;

  logic [NS-1:0]      vld;
  patan2_pkg::flags_t flg [NS];

  logic signed [RW-1:0]   s1_r;
  logic signed [2*RW-1:0] s2_rr;
  logic signed [RW-1:0]   s2_r;
  logic [16:0]            s3_r2;
  logic signed [RW-1:0]   s3_r;
  logic [29:0]            s4_m5;
  logic [16:0]            s4_r2;
  logic signed [RW-1:0]   s4_r;
  logic [14:0]            s5_t;
  logic [16:0]            s5_r2;
  logic signed [RW-1:0]   s5_r;
  logic [31:0]            s6_mrt;
  logic signed [RW-1:0]   s6_r;
  logic signed [RW-1:0]   s7_u;
  logic signed [RW-1:0]   s7_r;
  logic signed [2*RW-1:0] s8_mru;
  logic signed [TW-1:0]   s9_theta;

  logic signed [RW-1:0]   s1_r_next;
  logic [2*RW-1:0]        rr_rnd;
  logic [29:0]            m5_rnd;
  logic [14:0]            t_next;
  logic [31:0]            mrt_rnd;
  logic signed [RW-1:0]   u_next;
  logic [2*RW-1:0]        mru_rnd;
  logic signed [TW-1:0]   theta0;
  logic signed [TW-1:0]   theta_next;
  logic signed [TW-1:0]   a_val;
  logic signed [TW-1:0]   a_wrap;

  always_comb begin
    s1_r_next = in_flags.neg ? -$signed({1'b0, in_quot}) : $signed({1'b0, in_quot});
    rr_rnd    = s2_rr + (2*RW)'(32768);
    m5_rnd    = s4_m5 + 30'd32768;
    t_next    = 15'(patan2_pkg::COEF_C3) - {1'b0, m5_rnd[29:16]};
    mrt_rnd   = s6_mrt + 32'd32768;
    u_next    = $signed({2'b00, mrt_rnd[31:16]}) + $signed(RW'(patan2_pkg::COEF_C1));
    mru_rnd   = s8_mru + (2*RW)'(32768);
    theta0    = flg[7].xneg ? $signed(TW'(patan2_pkg::THREE_QUARTER_PI))
                            : $signed(TW'(patan2_pkg::QUARTER_PI));
    theta_next = theta0 + $signed(mru_rnd[2*RW-1:16]);
    // Negative angles get a full turn added; the scaler's modulo absorbs it.
    a_val  = flg[8].yneg ? -s9_theta : s9_theta;
    a_wrap = a_val[TW-1] ? a_val + $signed(TW'(patan2_pkg::TWO_PI)) : a_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    flg[0] <= in_flags;
    for (int i = 1; i < NS; i++) begin
      flg[i] <= flg[i-1];
    end
    s1_r     <= s1_r_next;
    s2_rr    <= s1_r * s1_r;
    s2_r     <= s1_r;
    s3_r2    <= rr_rnd[32:16];
    s3_r     <= s2_r;
    s4_m5    <= 30'(patan2_pkg::COEF_C5) * {13'd0, s3_r2};
    s4_r2    <= s3_r2;
    s4_r     <= s3_r;
    s5_t     <= t_next;
    s5_r2    <= s4_r2;
    s5_r     <= s4_r;
    s6_mrt   <= {15'd0, s5_r2} * {17'd0, s5_t};
    s6_r     <= s5_r;
    s7_u     <= u_next;
    s7_r     <= s6_r;
    s8_mru   <= s7_r * s7_u;
    s9_theta <= theta_next;
    turn_pos <= a_wrap;
  end

  assign out_valid = vld[NS-1];
  assign out_flags = flg[NS-1];

endmodule

[rtl/polynomial_atan2_top.sv]
// Top level of the pipelined polynomial atan2: coordinates in, angle out.
//
//   Channel   Handshake         Word
//   input     start / busy      y_value, x_value (signed coordinates)
//   output    done (one cycle)  angle (unsigned fraction of a full turn)
//
// The pipeline runs through the front end, the ratio divider, the polynomial
// stage and the scaler; most of its latency lies in the bit-per-stage divider.
// A new word may be started every cycle; busy is high only during reset.
// Reset clears all valid bits, so words in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
module polynomial_atan2_top #(
  parameter int COORD_WIDTH = patan2_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = patan2_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] y_value,
  input  logic signed [COORD_WIDTH-1:0] x_value,
  output logic                          done,
  output logic [ANGLE_WIDTH-1:0]        angle
);

  localparam int SBW = $bits(patan2_pkg::flags_t);
  localparam int SDW = patan2_pkg::SCALE_DW;
  localparam int QW  = ANGLE_WIDTH + 1;
  localparam int PW  = SDW + QW;
  localparam int LAT = patan2_pkg::FRONT_LAT + patan2_pkg::R_QBITS
                     + patan2_pkg::POLY_LAT + patan2_pkg::SCALE_LAT;

  // floor(2^(ANGLE_WIDTH+1+SCALE_SHIFT) / 4pi), the scaler's reciprocal.
  localparam logic [QW-1:0] SCALE_M =
    QW'((longint'(1) <<< (ANGLE_WIDTH + patan2_pkg::SCALE_SHIFT + 1))
        / longint'(patan2_pkg::TWO_PI_X2));

  logic                           accept;
  logic                           fe_valid;
  logic [COORD_WIDTH:0]           fe_rem0;
  logic [patan2_pkg::R_QBITS-1:0] fe_low;
  logic [COORD_WIDTH:0]           fe_den;
  patan2_pkg::flags_t             fe_flags;

  logic                           rd_valid;
  logic [patan2_pkg::R_QBITS-1:0] rd_quot;
  logic [COORD_WIDTH:0]           rd_rem;
  logic [SBW-1:0]                 rd_side;

  logic                           pl_valid;
  logic [SDW-1:0]                 pl_turn;
  patan2_pkg::flags_t             pl_flags;

  logic                           sc1_valid;
  logic [PW-1:0]                  sc1_prod;
  logic [SDW-1:0]                 sc1_turn;
  logic                           sc1_zero;

  logic                           sc2_valid;
  logic [QW-1:0]                  sc2_quot;
  logic [PW-1:0]                  sc2_qd;
  logic [PW-1:0]                  sc2_num;
  logic                           sc2_zero;

  logic [PW-1:0]                  sc_rem;
  logic [1:0]                     round_step;
  logic [QW-1:0]                  q_round;
  logic [ANGLE_WIDTH-1:0]         angle_next;

  assign busy   = rst;
  assign accept = start && !busy;

  patan2_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .y_in      (y_value),
    .x_in      (x_value),
    .out_valid (fe_valid),
    .rem0      (fe_rem0),
    .low       (fe_low),
    .den       (fe_den),
    .flags     (fe_flags)
  );

  patan2_divpipe #(
    .DW    (COORD_WIDTH + 1),
    .QBITS (patan2_pkg::R_QBITS),
    .SBW   (SBW)
  ) u_ratio_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fe_valid),
    .in_rem    (fe_rem0),
    .in_low    (fe_low),
    .in_div    (fe_den),
    .in_side   (fe_flags),
    .out_valid (rd_valid),
    .out_quot  (rd_quot),
    .out_rem   (rd_rem),
    .out_side  (rd_side)
  );

  patan2_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_quot   (rd_quot),
    .in_flags  (patan2_pkg::flags_t'(rd_side)),
    .out_valid (pl_valid),
    .turn_pos  (pl_turn),
    .out_flags (pl_flags)
  );

  // Angle scaling: floor((a * 2^(ANGLE_WIDTH+1) + 2pi) / 4pi). A reciprocal
  // multiply gives an estimate at most two below the quotient; the remainder
  // against 4pi then picks the final correction.
  always_ff @(posedge clk) begin
    if (rst) begin
      sc1_valid <= 1'b0;
      sc2_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      sc1_valid <= pl_valid;
      sc2_valid <= sc1_valid;
      done      <= sc2_valid;
    end
  end

  always_ff @(posedge clk) begin
    sc1_prod <= {{QW{1'b0}}, pl_turn} * {{SDW{1'b0}}, SCALE_M};
    sc1_turn <= pl_turn;
    sc1_zero <= pl_flags.zero;
    sc2_quot <= sc1_prod[patan2_pkg::SCALE_SHIFT +: QW];
    sc2_qd   <= {{SDW{1'b0}}, sc1_prod[patan2_pkg::SCALE_SHIFT +: QW]}
                * {{QW{1'b0}}, SDW'(patan2_pkg::TWO_PI_X2)};
    sc2_num  <= {sc1_turn, {QW{1'b0}}} + PW'(patan2_pkg::TWO_PI);
    sc2_zero <= sc1_zero;
  end

  always_comb begin
    sc_rem = sc2_num - sc2_qd;
    if (sc_rem >= PW'(2 * patan2_pkg::TWO_PI_X2)) begin
      round_step = 2'd2;
    end else if (sc_rem >= PW'(patan2_pkg::TWO_PI_X2)) begin
      round_step = 2'd1;
    end else begin
      round_step = 2'd0;
    end
    q_round    = sc2_quot + QW'(round_step);
    angle_next = sc2_zero ? '0 : q_round[ANGLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    angle <= angle_next;
  end

  // The rd_rem output of the ratio divider is not needed downstream.
  logic unused_rem;
  assign unused_rem = ^rd_rem;

  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted word produced no result after the pipeline latency");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result strobe without a matching accepted word");

  a_zero_input : assert property (@(posedge clk) disable iff (rst)
    (accept && x_value == '0 && y_value == '0) |-> ##LAT (angle == '0))
    else $error("zero vector did not give a zero angle");

  a_pos_x_axis : assert property (@(posedge clk) disable iff (rst)
    (accept && y_value == '0 && !x_value[COORD_WIDTH-1] && x_value != '0)
      |-> ##LAT (angle == '0))
    else $error("positive x axis did not give a zero angle");

endmodule
